// File: rtl/float_half_converter_assert.svh
// Assertion macros used by the checker file of the converter.
`ifndef FLOAT_HALF_CONVERTER_ASSERT_SVH
`define FLOAT_HALF_CONVERTER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, held off during reset.
`define FHC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("converter check failed");

// Next-cycle implication, sampled on the rising clock edge, held off during reset.
`define FHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("converter check failed");

`endif

// File: rtl/fhc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fhc_pkg;

  // Conversion direction carried with every beat.
  typedef enum logic {
    KIND_S2H = 1'b0,
    KIND_H2S = 1'b1
  } kind_e;

  // Exponent bias difference between single (127) and half (15).
  localparam logic [7:0] EXP_BIAS_ADJ   = 8'd112;
  // Smallest single exponent that still yields a nonzero half subnormal.
  localparam logic [7:0] SUB_EXP_MIN    = 8'd102;
  // Smallest single exponent that overflows the half range.
  localparam logic [7:0] INF_EXP_MIN    = 8'd143;
  // Right shift of the full single mantissa is this minus the exponent.
  localparam logic [7:0] SUB_SHIFT_BASE = 8'd126;
  // Single exponent of a half subnormal before the normalizing shift.
  localparam logic [7:0] SUB_EXP_BASE   = 8'd113;
  // All-ones exponents.
  localparam logic [4:0] HALF_EXP_MAX   = 5'h1F;
  localparam logic [7:0] SINGLE_EXP_MAX = 8'hFF;

  // One input beat as held in the input register.
  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
  } in_item_t;

endpackage

`default_nettype wire

// File: rtl/fhc_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Operand channel.
interface fhc_in_if;
  logic              valid;
  logic              ready;
  fhc_pkg::kind_e    kind;
  logic [31:0]       value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

// Result channel.
interface fhc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

// File: rtl/float_half_converter.sv
// Converts between single and half precision floating point, one beat per
// cycle in each direction chosen by the kind field of the beat. A beat passes
// an input register, one level of conversion logic and a result register;
// with the result side always ready the block sustains one beat every cycle.
// The input ready follows the result ready in the same cycle, so a stall on
// the result side holds two beats inside the block. Single to half truncates
// normal results, rounds subnormals half up, flushes values below 2^-25 to
// signed zero and turns overflow, infinity and NaN into signed infinity; a
// half result sits in the low 16 bits with the upper bits zero. Half to
// single is exact and ignores the upper 16 bits of the operand.
`timescale 1ns / 1ps
`default_nettype none

module float_half_converter (
  input  logic             clk_i,
  input  logic             rst_ni,
  fhc_in_if.sink           in_i,
  fhc_out_if.source        out_o
);
  import fhc_pkg::*;

  in_item_t    in_q;
  logic        in_valid_q;
  logic        in_valid_d;
  logic [31:0] result_q;
  logic [31:0] result_d;
  logic        out_valid_q;
  logic        out_valid_d;
  logic        in_accept;
  logic        out_load;
  logic [15:0] half_res;
  logic [31:0] single_res;

  // Handshake: the result register loads when the input register holds a beat and it is empty or being drained.
  assign out_load    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || out_load;
  assign in_accept   = in_i.valid && in_i.ready;
  assign in_valid_d  = in_accept || (in_valid_q && !out_load);
  assign out_valid_d = out_load || (out_valid_q && !out_o.ready);

  // Both directions are computed from the input register.
  fhc_s2h u_s2h (
    .single_i (in_q.value),
    .half_o   (half_res)
  );

  fhc_h2s u_h2s (
    .half_i   (in_q.value[15:0]),
    .single_o (single_res)
  );

  assign result_d = (in_q.kind == KIND_S2H) ? {16'b0, half_res} : single_res;

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q.kind  <= in_i.kind;
      in_q.value <= in_i.value;
    end
    if (out_load) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.result = result_q;

endmodule

`default_nettype wire

// File: rtl/fhc_s2h.sv
`timescale 1ns / 1ps
`default_nettype none

// Single to half: rebias, truncate normals, round subnormals half up.
module fhc_s2h (
  input  logic [31:0] single_i,
  output logic [15:0] half_o
);
  import fhc_pkg::*;

  logic        sign;
  logic [7:0]  exp_s;
  logic [23:0] mant_full;
  logic [7:0]  shift_full;
  logic [4:0]  shift;
  logic [23:0] shifted;
  logic [14:0] sub_mag;
  logic [7:0]  exp_reb;
  logic [14:0] mag;

  assign sign      = single_i[31];
  assign exp_s     = single_i[30:23];
  assign mant_full = {1'b1, single_i[22:0]};

  // Subnormal path: shift by one less than needed so bit 0 is the round bit.
  assign shift_full = SUB_SHIFT_BASE - exp_s;
  assign shift      = shift_full[4:0];
  assign shifted    = mant_full >> (shift - 5'd1);
  assign sub_mag    = {5'b0, shifted[10:1]} + {14'b0, shifted[0]};

  assign exp_reb = exp_s - EXP_BIAS_ADJ;

  // Pick the range: zero, subnormal, overflow to infinity, or normal.
  always_comb begin
    if (exp_s < SUB_EXP_MIN) begin
      mag = '0;
    end else if (exp_s <= EXP_BIAS_ADJ) begin
      mag = sub_mag;
    end else if (exp_s >= INF_EXP_MIN) begin
      mag = {HALF_EXP_MAX, 10'b0};
    end else begin
      mag = {exp_reb[4:0], single_i[22:13]};
    end
  end

  assign half_o = {sign, mag};

endmodule

`default_nettype wire

// File: rtl/fhc_h2s.sv
`timescale 1ns / 1ps
`default_nettype none

// Half to single: exact widening, subnormals normalized by a leading-zero count.
module fhc_h2s (
  input  logic [15:0] half_i,
  output logic [31:0] single_o
);
  import fhc_pkg::*;

  // Leading zeros of a ten-bit mantissa, counted from bit 9.
  function automatic logic [3:0] lead_zeros(logic [9:0] v);
    logic [3:0] n;
    logic       found;
    n     = '0;
    found = 1'b0;
    for (int i = 9; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) begin
          found = 1'b1;
        end else begin
          n = n + 4'd1;
        end
      end
    end
    return n;
  endfunction

  logic       sign;
  logic [4:0] exp_h;
  logic [9:0] mant;
  logic [3:0] norm_shift;
  logic [9:0] norm_mant;
  logic [7:0] sub_exp;

  assign sign  = half_i[15];
  assign exp_h = half_i[14:10];
  assign mant  = half_i[9:0];

  // The shift moves the leading one out past bit 9, where it is dropped.
  assign norm_shift = lead_zeros(mant) + 4'd1;
  assign norm_mant  = mant << norm_shift;
  assign sub_exp    = SUB_EXP_BASE - {4'b0, norm_shift};

  always_comb begin
    if (exp_h == '0) begin
      if (mant == '0) begin
        single_o = {sign, 31'b0};
      end else begin
        single_o = {sign, sub_exp, norm_mant, 13'b0};
      end
    end else if (exp_h == HALF_EXP_MAX) begin
      single_o = {sign, SINGLE_EXP_MAX, mant, 13'b0};
    end else begin
      single_o = {sign, {3'b0, exp_h} + EXP_BIAS_ADJ, mant, 13'b0};
    end
  end

endmodule

`default_nettype wire

// File: rtl/fhc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "float_half_converter_assert.svh"

// Port-level checks: beats in flight are tracked from the two handshakes.
module fhc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_result_i
);
  logic       in_beat;
  logic       out_beat;
  logic [2:0] pending_q;
  logic [2:0] pending_d;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  // Count of beats accepted but not yet delivered.
  always_comb begin
    pending_d = pending_q;
    if (in_beat && !out_beat) begin
      pending_d = pending_q + 3'd1;
    end else if (out_beat && !in_beat) begin
      pending_d = pending_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // The block holds at most two beats: input register and result register.
  `FHC_ASSERT_NOW(a_capacity, clk_i, rst_ni, 1'b1, pending_q <= 3'd2)
  // No result is offered without an accepted operand behind it.
  `FHC_ASSERT_NOW(a_no_phantom, clk_i, rst_ni, out_valid_i, pending_q != 3'd0)
  // An empty block always takes an operand.
  `FHC_ASSERT_NOW(a_ready_empty, clk_i, rst_ni, pending_q == 3'd0, in_ready_i)
  // A stalled result stays offered and unchanged.
  `FHC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(out_result_i))

endmodule

bind float_half_converter fhc_checker u_fhc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_result_i (out_o.result)
);

`default_nettype wire
